// File: hdl/rfcs_pkg.sv
// rfcs_pkg: shared constants, types and sequencer states for the colour spread block
`default_nettype none

package rfcs_pkg;

   // frame size limit and derived accumulator widths
   localparam int MAX_PIXELS_LOG2 = 21;
   localparam int CHAN_N          = 3;
   localparam int CHAN_W          = $clog2(CHAN_N);
   localparam int PIX_VAL_W       = 8;
   localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
   localparam int SUM_W           = MAX_PIXELS_LOG2 + PIX_VAL_W;
   localparam int SQ_W            = MAX_PIXELS_LOG2 + 2 * PIX_VAL_W;

   // result field widths
   localparam int Y_W   = 14;
   localparam int PIX_W = 22;
   localparam int BIT_W = $clog2(Y_W);

   // scale factors: 100 * 256 squared and 3 * 255 squared
   localparam int NUM_W = 30;
   localparam int DEN_W = 18;
   localparam logic [NUM_W-1:0] SCALE_NUM = NUM_W'(655360000);
   localparam logic [DEN_W-1:0] SCALE_DEN = DEN_W'(195075);

   // wide working registers hold T * SCALE_NUM and the root comparands
   localparam int ACC_W      = 2 * MAX_PIXELS_LOG2 + 49;
   localparam int MUL_W      = (SUM_W > NUM_W) ? SUM_W : NUM_W;
   localparam int STEP_W     = $clog2(MUL_W + 1);
   localparam int ROOT_SHIFT = 2 * (Y_W - 1);

   localparam logic [CNT_W-1:0]  MAX_PIXELS = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};
   localparam logic [Y_W-1:0]    SPREAD_MAX = Y_W'(12800);
   localparam logic [STEP_W-1:0] STEPS_CNT  = STEP_W'(CNT_W);
   localparam logic [STEP_W-1:0] STEPS_SUM  = STEP_W'(SUM_W);
   localparam logic [STEP_W-1:0] STEPS_NUM  = STEP_W'(NUM_W);
   localparam logic [STEP_W-1:0] STEPS_DEN  = STEP_W'(DEN_W);
   localparam logic [CHAN_W-1:0] LAST_CHAN  = CHAN_W'(CHAN_N - 1);
   localparam logic [BIT_W-1:0]  TOP_BIT    = BIT_W'(Y_W - 1);

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHQ_SETUP,
      ST_CHQ_RUN,
      ST_CHS_SETUP,
      ST_CHS_RUN,
      ST_SCALE_SETUP,
      ST_SCALE_RUN,
      ST_NSQ_SETUP,
      ST_NSQ_RUN,
      ST_DEN_SETUP,
      ST_DEN_RUN,
      ST_ROOT_SETUP,
      ST_ROOT_SUM,
      ST_ROOT_TRY,
      ST_ROOT_NEXT,
      ST_FINISH
   } state_type;

   // accumulator status seen by the sequencer
   typedef struct packed {
      logic [CHAN_N-1:0][SUM_W-1:0] sum;
      logic [CHAN_N-1:0][SQ_W-1:0]  sq;
      logic [CNT_W-1:0]             count;
      logic                         overflow;
   } acc_stat_type;

   // shared adder request and result
   typedef struct packed {
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
      logic             sub;
   } alu_op_type;

   typedef struct packed {
      logic [ACC_W-1:0] sum;
      logic             borrow;
   } alu_res_type;

endpackage

`default_nettype wire

// File: hdl/rfcs_if.sv
// rfcs_if: pixel request and spread response channel interfaces
`default_nettype none

interface rfcs_req_if;
   logic                           valid;
   logic                           ready;
   logic [rfcs_pkg::PIX_VAL_W-1:0] red;
   logic [rfcs_pkg::PIX_VAL_W-1:0] green;
   logic [rfcs_pkg::PIX_VAL_W-1:0] blue;
   logic                           frame_end;

   modport source (output valid, red, green, blue, frame_end, input ready);
   modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

interface rfcs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rfcs_pkg::Y_W-1:0]   spread_pct_q8;
   logic [rfcs_pkg::PIX_W-1:0] pixel_total;
   logic                       overflow;

   modport source (output valid, spread_pct_q8, pixel_total, overflow, input ready);
   modport sink   (input valid, spread_pct_q8, pixel_total, overflow, output ready);
endinterface

`default_nettype wire

// File: hdl/rfcs_addsub.sv
// rfcs_addsub: the one wide adder/subtractor shared by every multiply and root step of rfcs_seq
`default_nettype none

module rfcs_addsub (
   input  rfcs_pkg::alu_op_type  alu_op,
   output rfcs_pkg::alu_res_type alu_res
);

   logic [rfcs_pkg::ACC_W:0] full;

   // one extra bit gives the borrow of a subtraction
   always_comb begin
      if (alu_op.sub) begin
         full = {1'b0, alu_op.a} - {1'b0, alu_op.b};
      end else begin
         full = {1'b0, alu_op.a} + {1'b0, alu_op.b};
      end
      alu_res.sum    = full[rfcs_pkg::ACC_W-1:0];
      alu_res.borrow = full[rfcs_pkg::ACC_W];
   end

endmodule

`default_nettype wire

// File: hdl/rfcs_accum.sv
// rfcs_accum: per-channel sums, sums of squares, pixel count and overflow flag
`default_nettype none

module rfcs_accum (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                take,
   input  logic [rfcs_pkg::CHAN_N-1:0][rfcs_pkg::PIX_VAL_W-1:0] pix,
   input  logic                                                clear,
   output rfcs_pkg::acc_stat_type                              acc_st
);

   logic [rfcs_pkg::CHAN_N-1:0][rfcs_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [rfcs_pkg::CHAN_N-1:0][rfcs_pkg::SQ_W-1:0]  sq_ff, sq_in;
   logic [rfcs_pkg::CNT_W-1:0]                      count_ff, count_in;
   logic                                            ovf_ff, ovf_in;
   logic [2*rfcs_pkg::PIX_VAL_W-1:0]                square;
   logic                                            room;

   // clear empties the frame; otherwise accumulate a pixel while the frame has room, else flag it
   always_comb begin
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      square   = '0;
      room     = (count_ff != rfcs_pkg::MAX_PIXELS);
      if (clear) begin
         sum_in   = '0;
         sq_in    = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (take) begin
         if (room) begin
            for (int c = 0; c < rfcs_pkg::CHAN_N; c++) begin
               square   = pix[c] * pix[c];
               sum_in[c] = sum_ff[c] + rfcs_pkg::SUM_W'(pix[c]);
               sq_in[c]  = sq_ff[c] + rfcs_pkg::SQ_W'(square);
            end
            count_in = count_ff + rfcs_pkg::CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sq_ff    <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign acc_st.sum      = sum_ff;
   assign acc_st.sq       = sq_ff;
   assign acc_st.count    = count_ff;
   assign acc_st.overflow = ovf_ff;

endmodule

`default_nettype wire

// File: hdl/rfcs_seq.sv
// rfcs_seq: end-of-frame sequencer driving the shared adder for variance, scale and root
`default_nettype none

module rfcs_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rfcs_pkg::acc_stat_type acc_st,
   output logic                   clear,
   output logic                   in_ready,
   rfcs_rsp_if.source             rsp
);

   rfcs_pkg::state_type             state_ff, state_in;
   logic [rfcs_pkg::CHAN_W-1:0]     chan_ff, chan_in;
   logic [rfcs_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [rfcs_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic [rfcs_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic [rfcs_pkg::ACC_W-1:0]      mreg_ff, mreg_in;
   logic [rfcs_pkg::MUL_W-1:0]      mulr_ff, mulr_in;
   logic [rfcs_pkg::ACC_W-1:0]      rem_ff, rem_in;
   logic [rfcs_pkg::ACC_W-1:0]      tmp_ff, tmp_in;
   logic                            take_ff, take_in;
   logic [rfcs_pkg::Y_W-1:0]        y_ff, y_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rfcs_pkg::Y_W-1:0]        rsp_spread_ff, rsp_spread_in;
   logic [rfcs_pkg::PIX_W-1:0]      rsp_total_ff, rsp_total_in;
   logic                            rsp_ovf_ff, rsp_ovf_in;
   logic                            last_step;
   logic                            out_free;
   rfcs_pkg::alu_op_type            alu_op;
   rfcs_pkg::alu_res_type           alu_out;

   rfcs_addsub u_addsub (
      .alu_op  (alu_op),
      .alu_res (alu_out)
   );

   assign last_step = (step_ff == rfcs_pkg::STEP_W'(1));
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rfcs_pkg::ST_IDLE: begin
            if (start) begin
               state_in = rfcs_pkg::ST_CHQ_SETUP;
            end
         end
         rfcs_pkg::ST_CHQ_SETUP:   state_in = rfcs_pkg::ST_CHQ_RUN;
         rfcs_pkg::ST_CHQ_RUN: begin
            if (last_step) begin
               state_in = rfcs_pkg::ST_CHS_SETUP;
            end
         end
         rfcs_pkg::ST_CHS_SETUP:   state_in = rfcs_pkg::ST_CHS_RUN;
         rfcs_pkg::ST_CHS_RUN: begin
            if (last_step) begin
               if (chan_ff == rfcs_pkg::LAST_CHAN) begin
                  state_in = rfcs_pkg::ST_SCALE_SETUP;
               end else begin
                  state_in = rfcs_pkg::ST_CHQ_SETUP;
               end
            end
         end
         rfcs_pkg::ST_SCALE_SETUP: state_in = rfcs_pkg::ST_SCALE_RUN;
         rfcs_pkg::ST_SCALE_RUN: begin
            if (last_step) begin
               state_in = rfcs_pkg::ST_NSQ_SETUP;
            end
         end
         rfcs_pkg::ST_NSQ_SETUP:   state_in = rfcs_pkg::ST_NSQ_RUN;
         rfcs_pkg::ST_NSQ_RUN: begin
            if (last_step) begin
               state_in = rfcs_pkg::ST_DEN_SETUP;
            end
         end
         rfcs_pkg::ST_DEN_SETUP:   state_in = rfcs_pkg::ST_DEN_RUN;
         rfcs_pkg::ST_DEN_RUN: begin
            if (last_step) begin
               state_in = rfcs_pkg::ST_ROOT_SETUP;
            end
         end
         rfcs_pkg::ST_ROOT_SETUP:  state_in = rfcs_pkg::ST_ROOT_SUM;
         rfcs_pkg::ST_ROOT_SUM:    state_in = rfcs_pkg::ST_ROOT_TRY;
         rfcs_pkg::ST_ROOT_TRY:    state_in = rfcs_pkg::ST_ROOT_NEXT;
         rfcs_pkg::ST_ROOT_NEXT: begin
            if (bit_ff == '0) begin
               state_in = rfcs_pkg::ST_FINISH;
            end else begin
               state_in = rfcs_pkg::ST_ROOT_SUM;
            end
         end
         rfcs_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = rfcs_pkg::ST_IDLE;
            end
         end
         default:                  state_in = rfcs_pkg::ST_IDLE;
      endcase
   end

   // shared adder operands
   always_comb begin
      alu_op.a   = acc_ff;
      alu_op.b   = mreg_ff;
      alu_op.sub = 1'b0;
      unique case (state_ff)
         rfcs_pkg::ST_CHS_RUN: begin
            alu_op.sub = 1'b1;
         end
         rfcs_pkg::ST_ROOT_TRY: begin
            alu_op.a   = rem_ff;
            alu_op.b   = tmp_ff;
            alu_op.sub = 1'b1;
         end
         rfcs_pkg::ST_ROOT_NEXT: begin
            alu_op.a = tmp_ff;
         end
         default: begin
            alu_op.sub = 1'b0;
         end
      endcase
   end

   // datapath register updates per state
   always_comb begin
      chan_in       = chan_ff;
      step_in       = step_ff;
      bit_in        = bit_ff;
      acc_in        = acc_ff;
      mreg_in       = mreg_ff;
      mulr_in       = mulr_ff;
      rem_in        = rem_ff;
      tmp_in        = tmp_ff;
      take_in       = take_ff;
      y_in          = y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_spread_in = rsp_spread_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      clear         = 1'b0;
      unique case (state_ff) inside
         rfcs_pkg::ST_IDLE: begin
            if (start) begin
               acc_in  = '0;
               chan_in = '0;
            end
         end
         // n times the channel square sum, added into T
         rfcs_pkg::ST_CHQ_SETUP: begin
            mreg_in = rfcs_pkg::ACC_W'(acc_st.sq[chan_ff]);
            mulr_in = rfcs_pkg::MUL_W'(acc_st.count);
            step_in = rfcs_pkg::STEPS_CNT;
         end
         // channel sum squared, taken off T
         rfcs_pkg::ST_CHS_SETUP: begin
            mreg_in = rfcs_pkg::ACC_W'(acc_st.sum[chan_ff]);
            mulr_in = rfcs_pkg::MUL_W'(acc_st.sum[chan_ff]);
            step_in = rfcs_pkg::STEPS_SUM;
         end
         // right-hand side of the root test: T times the numerator scale
         rfcs_pkg::ST_SCALE_SETUP: begin
            mreg_in = acc_ff;
            acc_in  = '0;
            mulr_in = rfcs_pkg::MUL_W'(rfcs_pkg::SCALE_NUM);
            step_in = rfcs_pkg::STEPS_NUM;
         end
         // park the scaled T as the remainder, then n squared
         rfcs_pkg::ST_NSQ_SETUP: begin
            rem_in  = acc_ff;
            acc_in  = '0;
            mreg_in = rfcs_pkg::ACC_W'(acc_st.count);
            mulr_in = rfcs_pkg::MUL_W'(acc_st.count);
            step_in = rfcs_pkg::STEPS_CNT;
         end
         // n squared times the denominator scale
         rfcs_pkg::ST_DEN_SETUP: begin
            mreg_in = acc_ff;
            acc_in  = '0;
            mulr_in = rfcs_pkg::MUL_W'(rfcs_pkg::SCALE_DEN);
            step_in = rfcs_pkg::STEPS_DEN;
         end
         rfcs_pkg::ST_CHQ_RUN, rfcs_pkg::ST_CHS_RUN, rfcs_pkg::ST_SCALE_RUN,
         rfcs_pkg::ST_NSQ_RUN, rfcs_pkg::ST_DEN_RUN: begin
            if (mulr_ff[0]) begin
               acc_in = alu_out.sum;
            end
            mreg_in = mreg_ff << 1;
            mulr_in = mulr_ff >> 1;
            step_in = step_ff - rfcs_pkg::STEP_W'(1);
            if (state_ff == rfcs_pkg::ST_CHS_RUN && last_step &&
                chan_ff != rfcs_pkg::LAST_CHAN) begin
               chan_in = chan_ff + rfcs_pkg::CHAN_W'(1);
            end
         end
         // root search: mreg holds M << 2b, acc holds (M * y) << (b + 1)
         rfcs_pkg::ST_ROOT_SETUP: begin
            mreg_in = acc_ff << rfcs_pkg::ROOT_SHIFT;
            acc_in  = '0;
            bit_in  = rfcs_pkg::TOP_BIT;
            y_in    = '0;
         end
         rfcs_pkg::ST_ROOT_SUM: begin
            tmp_in = alu_out.sum;
         end
         rfcs_pkg::ST_ROOT_TRY: begin
            take_in = !alu_out.borrow;
            if (!alu_out.borrow) begin
               rem_in = alu_out.sum;
            end
         end
         rfcs_pkg::ST_ROOT_NEXT: begin
            acc_in  = (take_ff ? alu_out.sum : acc_ff) >> 1;
            mreg_in = mreg_ff >> 2;
            if (take_ff) begin
               y_in[bit_ff] = 1'b1;
            end
            if (bit_ff != '0) begin
               bit_in = bit_ff - rfcs_pkg::BIT_W'(1);
            end
         end
         // hand the result to the output register and clear the frame
         rfcs_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_spread_in = y_ff;
               rsp_total_in  = rfcs_pkg::PIX_W'(acc_st.count);
               rsp_ovf_in    = acc_st.overflow;
               clear         = 1'b1;
            end
         end
         default: begin
            clear = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      chan_ff       <= chan_in;
      step_ff       <= step_in;
      bit_ff        <= bit_in;
      acc_ff        <= acc_in;
      mreg_ff       <= mreg_in;
      mulr_ff       <= mulr_in;
      rem_ff        <= rem_in;
      tmp_ff        <= tmp_in;
      take_ff       <= take_in;
      y_ff          <= y_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign in_ready          = (state_ff == rfcs_pkg::ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.spread_pct_q8 = rsp_spread_ff;
   assign rsp.pixel_total   = rsp_total_ff;
   assign rsp.overflow      = rsp_ovf_ff;

endmodule

`default_nettype wire

// File: hdl/rgb_frame_colour_spread.sv
// rgb_frame_colour_spread: pooled RGB standard deviation per frame, top level
//
//   channel   direction  carries
//   req_ch    in         one pixel: red, green, blue, frame_end
//   rsp_ch    out        spread_pct_q8, pixel_total, overflow per frame
//
// Pixels without frame_end stream at one per clock while the sequencer is idle.
// After the frame_end transfer the sequencer runs on its single shared wide adder,
// with req_ch.ready low.
// The result sits in an output register; a new frame may fill while it waits, and the
// sequencer holds in its last state only if the previous result is still untaken.
// Synchronous active-high reset clears the accumulators, sequencer and rsp_ch.valid.
`default_nettype none

module rgb_frame_colour_spread (
   input  logic       clock,
   input  logic       reset,
   rfcs_req_if.sink   req_ch,
   rfcs_rsp_if.source rsp_ch
);

   logic                                                pix_take;
   logic                                                frame_start;
   logic                                                acc_clear;
   logic                                                seq_ready;
   logic [rfcs_pkg::CHAN_N-1:0][rfcs_pkg::PIX_VAL_W-1:0] pix;
   rfcs_pkg::acc_stat_type                              acc_st;

   // pixel transfer and start of the end-of-frame sequence
   assign req_ch.ready = seq_ready;
   assign pix_take     = req_ch.valid && seq_ready;
   assign frame_start  = pix_take && req_ch.frame_end;
   assign pix          = {req_ch.blue, req_ch.green, req_ch.red};

   rfcs_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .take   (pix_take),
      .pix    (pix),
      .clear  (acc_clear),
      .acc_st (acc_st)
   );

   rfcs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (frame_start),
      .acc_st   (acc_st),
      .clear    (acc_clear),
      .in_ready (seq_ready),
      .rsp      (rsp_ch)
   );

`ifndef SYNTHESIS
   // the sequencer takes over right after a frame-end transfer
   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.frame_end) |=> !req_ch.ready)
      else $error("pixel channel still ready after frame end");

   // a pixel arriving at a full frame raises the overflow flag
   a_overflow_set: assert property (@(posedge clock) disable iff (reset)
      (pix_take && acc_st.count == rfcs_pkg::MAX_PIXELS) |=> acc_st.overflow)
      else $error("dropped pixel not flagged");

   // clearing leaves an empty frame behind
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      acc_clear |=> (acc_st.count == '0 && !acc_st.overflow))
      else $error("accumulators not cleared after result");

   // the spread never exceeds half of full scale
   a_spread_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.spread_pct_q8 <= rfcs_pkg::SPREAD_MAX))
      else $error("spread result out of range");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: streams pixel frames into rgb_frame_colour_spread and checks every frame result
`default_nettype none

module testbench;

   localparam int RESET_CYCLES = 10;
   localparam int IDLE_PCT     = 27;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CALM_ITEMS   = 300;
   localparam int HOLD_AT      = 10;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 7 * rfcs_pkg::MAX_PIXELS_LOG2 + 129 + 64;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SCRIPT_LEN   = 14;

   // (100 * 256) squared, and 3 * 255 squared
   localparam logic [127:0] PCT_Q8_SQ    = 128'd655360000;
   localparam logic [127:0] FULL_SQ_X3   = 128'd195075;

   typedef struct packed {
      logic [rfcs_pkg::Y_W-1:0]   spread;
      logic [rfcs_pkg::PIX_W-1:0] total;
      logic                       ovf;
   } frame_result_type;

   typedef struct {
      logic [rfcs_pkg::PIX_VAL_W-1:0] red;
      logic [rfcs_pkg::PIX_VAL_W-1:0] green;
      logic [rfcs_pkg::PIX_VAL_W-1:0] blue;
      logic                           frame_end;
      bit                             typed;
      frame_result_type               want;
   } pixel_row_type;

   typedef enum int {MIX_ANY, MIX_RAILS, MIX_NARROW, MIX_FLAT} mix_kind_type;

   logic clock = 1'b0;
   logic reset;

   rfcs_req_if req_ch ();
   rfcs_rsp_if rsp_ch ();

   rgb_frame_colour_spread u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // running frame sums kept alongside the block
   logic [rfcs_pkg::SUM_W-1:0] sum_acc [rfcs_pkg::CHAN_N];
   logic [rfcs_pkg::SQ_W-1:0]  sq_acc  [rfcs_pkg::CHAN_N];
   logic [rfcs_pkg::CNT_W-1:0] pix_acc;
   logic                       dropped;

   frame_result_type results_due [$];
   int unsigned      fail_count     = 0;
   int unsigned      frames_checked = 0;
   int unsigned      cycle_count    = 0;
   int unsigned      hold_left      = 0;
   bit               held           = 1'b0;
   bit               calm;

   // directed frames: single pixels, rails, flat colour, primaries, mixed bit patterns
   pixel_row_type script [SCRIPT_LEN] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, '{14'd0, 22'd1, 1'b0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, '{14'd0, 22'd1, 1'b0}},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, '{rfcs_pkg::SPREAD_MAX, 22'd2, 1'b0}},
      '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd0,   8'd255, 1'b1, 1'b0, '0},
      '{8'd100, 8'd100, 8'd100, 1'b0, 1'b0, '0},
      '{8'd100, 8'd100, 8'd100, 1'b0, 1'b0, '0},
      '{8'd100, 8'd100, 8'd100, 1'b1, 1'b1, '{14'd0, 22'd3, 1'b0}},
      '{8'd170, 8'd85,  8'd15,  1'b0, 1'b0, '0},
      '{8'd85,  8'd170, 8'd240, 1'b0, 1'b0, '0},
      '{8'd1,   8'd2,   8'd4,   1'b0, 1'b0, '0},
      '{8'd128, 8'd64,  8'd32,  1'b1, 1'b0, '0}
   };

   function automatic void clear_frame();
      for (int c = 0; c < rfcs_pkg::CHAN_N; c++) begin
         sum_acc[c] = '0;
         sq_acc[c]  = '0;
      end
      pix_acc = '0;
      dropped = 1'b0;
   endfunction

   // pooled spread of the frame so far, then clear for the next frame
   function automatic frame_result_type frame_spread();
      frame_result_type         res;
      logic [127:0]             dev_sq;
      logic [127:0]             n_sq_prod;
      logic [127:0]             sum_sq;
      logic [127:0]             n_sq;
      logic [127:0]             lhs;
      logic [rfcs_pkg::Y_W-1:0] y;
      logic [rfcs_pkg::Y_W-1:0] trial;
      dev_sq = '0;
      y      = '0;
      if (pix_acc != '0) begin
         for (int c = 0; c < rfcs_pkg::CHAN_N; c++) begin
            n_sq_prod = 128'(pix_acc) * 128'(sq_acc[c]);
            sum_sq    = 128'(sum_acc[c]) * 128'(sum_acc[c]);
            if (sum_sq <= n_sq_prod) begin
               dev_sq += n_sq_prod - sum_sq;
            end
         end
         dev_sq = dev_sq * PCT_Q8_SQ;
         n_sq   = 128'(pix_acc) * 128'(pix_acc);
         // largest y with y^2 * 3 * 255^2 * n^2 <= (100 * 256)^2 * T
         for (int b_i = rfcs_pkg::Y_W - 1; b_i >= 0; b_i--) begin
            trial = y | (rfcs_pkg::Y_W'(1) << b_i);
            lhs   = 128'(trial) * 128'(trial) * FULL_SQ_X3 * n_sq;
            if (lhs <= dev_sq) begin
               y = trial;
            end
         end
      end
      res.spread = y;
      res.total  = rfcs_pkg::PIX_W'(pix_acc);
      res.ovf    = dropped;
      clear_frame();
      return res;
   endfunction

   // offer one pixel, wait for the transfer, then fold it into the running sums; a frame's last pixel queues its result
   task automatic send_pixel(input logic [rfcs_pkg::PIX_VAL_W-1:0] r,
                             input logic [rfcs_pkg::PIX_VAL_W-1:0] g,
                             input logic [rfcs_pkg::PIX_VAL_W-1:0] b, input logic last,
                             input bit typed, input frame_result_type want);
      logic [rfcs_pkg::PIX_VAL_W-1:0] px [rfcs_pkg::CHAN_N];
      frame_result_type               got;
      px[0] = r;
      px[1] = g;
      px[2] = b;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.red       <= r;
      req_ch.green     <= g;
      req_ch.blue      <= b;
      req_ch.frame_end <= last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      if (pix_acc < rfcs_pkg::MAX_PIXELS) begin
         for (int c = 0; c < rfcs_pkg::CHAN_N; c++) begin
            sum_acc[c] += rfcs_pkg::SUM_W'(px[c]);
            sq_acc[c]  += rfcs_pkg::SQ_W'(px[c]) * rfcs_pkg::SQ_W'(px[c]);
         end
         pix_acc++;
      end else begin
         dropped = 1'b1;
      end
      if (last) begin
         got = frame_spread();
         results_due.push_back(typed ? want : got);
      end
   endtask

   // result side: compare each transfer, then choose ready for the next cycle
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            frames_checked++;
            if (results_due.size() == 0) begin
               $error("result with no frame pending: spread_pct_q8 %0d pixel_total %0d",
                      rsp_ch.spread_pct_q8, rsp_ch.pixel_total);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_ch.spread_pct_q8 !== want.spread) begin
                  $error("spread_pct_q8: expected %0d, actual %0d",
                         want.spread, rsp_ch.spread_pct_q8);
                  fail_count++;
               end
               if (rsp_ch.pixel_total !== want.total) begin
                  $error("pixel_total: expected %0d, actual %0d",
                         want.total, rsp_ch.pixel_total);
                  fail_count++;
               end
               if (rsp_ch.overflow !== want.ovf) begin
                  $error("overflow: expected %0d, actual %0d", want.ovf, rsp_ch.overflow);
                  fail_count++;
               end
            end
         end
         // one long hold-off so that finished frames back up into the pixel input
         if (!held && frames_checked == HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int                             sent;
      int                             span;
      mix_kind_type                   mix;
      logic [rfcs_pkg::PIX_VAL_W-1:0] r;
      logic [rfcs_pkg::PIX_VAL_W-1:0] g;
      logic [rfcs_pkg::PIX_VAL_W-1:0] b;
      logic [rfcs_pkg::PIX_VAL_W-1:0] fr;
      logic [rfcs_pkg::PIX_VAL_W-1:0] fg;
      logic [rfcs_pkg::PIX_VAL_W-1:0] fb;
      logic [rfcs_pkg::PIX_VAL_W-1:0] base;
      clear_frame();
      reset            <= 1'b1;
      calm             <= 1'b0;
      req_ch.valid     <= 1'b0;
      req_ch.red       <= '0;
      req_ch.green     <= '0;
      req_ch.blue      <= '0;
      req_ch.frame_end <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      foreach (script[i]) begin
         send_pixel(script[i].red, script[i].green, script[i].blue, script[i].frame_end,
                    script[i].typed, script[i].want);
      end

      // random frames, mostly short, a few long; the first stretch runs with no idling
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mix  = mix_kind_type'($urandom_range(3));
         span = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
         base = rfcs_pkg::PIX_VAL_W'($urandom);
         fr   = rfcs_pkg::PIX_VAL_W'($urandom);
         fg   = rfcs_pkg::PIX_VAL_W'($urandom);
         fb   = rfcs_pkg::PIX_VAL_W'($urandom);
         calm <= (sent < CALM_ITEMS) || ($urandom_range(7) == 0);
         for (int k = 0; k < span; k++) begin
            case (mix)
               MIX_RAILS: begin
                  r = $urandom_range(1) ? '1 : '0;
                  g = $urandom_range(1) ? '1 : '0;
                  b = $urandom_range(1) ? '1 : '0;
               end
               MIX_NARROW: begin
                  r = rfcs_pkg::PIX_VAL_W'(base + $urandom_range(3));
                  g = rfcs_pkg::PIX_VAL_W'(base + $urandom_range(3));
                  b = rfcs_pkg::PIX_VAL_W'(base + $urandom_range(3));
               end
               MIX_FLAT: begin
                  r = fr;
                  g = fg;
                  b = fb;
               end
               default: begin
                  r = rfcs_pkg::PIX_VAL_W'($urandom);
                  g = rfcs_pkg::PIX_VAL_W'($urandom);
                  b = rfcs_pkg::PIX_VAL_W'($urandom);
               end
            endcase
            send_pixel(r, g, b, k == span - 1, 1'b0, '0);
         end
         sent += span;
      end
      req_ch.valid <= 1'b0;

      // let the last frame finish, then watch for stray results
      while (results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
